FILE: hdl/dvom_pkg.sv
`timescale 1ns / 1ps

package dvom_pkg;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic cfg_we;    // write the vertex count register
    logic edge_rd;   // latch an edge request and read its source row
    logic edge_rej;  // report a rejected edge request
    logic edge_wr;   // merge the edge bit into the row and report
    logic run_init;  // clear visited bits, counter, stack depth, output index
    logic sel_root;  // search for the lowest unvisited root instead of a neighbor
    logic visit;     // number, mark and push the vertex that the search found
    logic pop;       // drop the stack top and read the entry below it
    logic pop_load;  // read the adjacency row of the new stack top
    logic out_step;  // read the next mark and report it
  } dvom_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic edge_bad;  // pending edge request has a vertex out of range
    logic found;     // search found a vertex
    logic depth_one; // stack holds a single entry
    logic out_last;  // output index points at the last vertex
  } dvom_sts_t;

endpackage

FILE: hdl/dfs_visit_order_marker_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// request   in         start & !busy                  mode_i, from_vertex_i, to_vertex_i
// result    out        result_valid_o, one cycle      vertex_index_o, mark_value_o,
//                                                     last_item_o, edge_rejected_o
// config    in         cfg_valid_i & cfg_ready_o      cfg_data_i (vertex count)
//
// Edge request: an accepted edge passes through the write state and the
// result register; a rejected one goes straight there and never raises busy.
// Run request: the sequencer visits one vertex per cycle, pops a stack entry and
// reloads the new top's row (not when the stack empties), then reads one mark per
// cycle to report it. Reset clears the adjacency matrix at once through per-row
// valid bits. Results cannot be stalled; busy drops as the last one appears.
module dfs_visit_order_marker_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [5:0] from_vertex_i,
  input  logic [5:0] to_vertex_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [5:0] vertex_index_o,
  output logic [6:0] mark_value_o,
  output logic       last_item_o,
  output logic       edge_rejected_o
);

  dvom_pkg::dvom_cmd_t cmd;
  dvom_pkg::dvom_sts_t sts;

  dvom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .mode_i     (mode_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dvom_dpath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_data_i     (cfg_data_i),
    .from_vertex_i  (from_vertex_i),
    .to_vertex_i    (to_vertex_i),
    .result_valid_o (result_valid_o),
    .vertex_index_o (vertex_index_o),
    .mark_value_o   (mark_value_o),
    .last_item_o    (last_item_o),
    .edge_rejected_o(edge_rejected_o)
  );

endmodule

FILE: hdl/dvom_ram.sv
`timescale 1ns / 1ps

module dvom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dvom_ctrl.sv
`timescale 1ns / 1ps

module dvom_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  dvom_pkg::dvom_sts_t sts_i,
  output dvom_pkg::dvom_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StEdgeWr = 3'd1;
  localparam logic [2:0] StInit   = 3'd2;
  localparam logic [2:0] StRoot   = 3'd3;
  localparam logic [2:0] StSearch = 3'd4;
  localparam logic [2:0] StPop    = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  logic [2:0] state_q, state_d;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = ~busy;

  // Sequence edge requests and runs
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.cfg_we = cfg_valid_i & ~busy;
    case (state_q)
      StIdle: begin
        if (start) begin
          if (mode_i) begin
            state_d = StInit;
          end else if (sts_i.edge_bad) begin
            cmd_o.edge_rej = 1'b1;
          end else begin
            cmd_o.edge_rd = 1'b1;
            state_d       = StEdgeWr;
          end
        end
      end
      StEdgeWr: begin
        cmd_o.edge_wr = 1'b1;
        state_d       = StIdle;
      end
      StInit: begin
        cmd_o.run_init = 1'b1;
        state_d        = StRoot;
      end
      StRoot: begin
        cmd_o.sel_root = 1'b1;
        if (sts_i.found) begin
          cmd_o.visit = 1'b1;
          state_d     = StSearch;
        end else begin
          state_d = StOut;
        end
      end
      StSearch: begin
        if (sts_i.found) begin
          cmd_o.visit = 1'b1;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.depth_one ? StRoot : StPop;
        end
      end
      StPop: begin
        cmd_o.pop_load = 1'b1;
        state_d        = StSearch;
      end
      StOut: begin
        cmd_o.out_step = 1'b1;
        if (sts_i.out_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/dvom_dpath.sv
`timescale 1ns / 1ps

module dvom_dpath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dvom_pkg::dvom_cmd_t cmd_i,
  output dvom_pkg::dvom_sts_t sts_o,
  input  logic [6:0]          cfg_data_i,
  input  logic [5:0]          from_vertex_i,
  input  logic [5:0]          to_vertex_i,
  output logic                result_valid_o,
  output logic [5:0]          vertex_index_o,
  output logic [6:0]          mark_value_o,
  output logic                last_item_o,
  output logic                edge_rejected_o
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [6:0] MaxN = 7'(MAX_VERTICES);

  // Configuration and run state
  logic [CNT_W-1:0]        n_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        depth_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [IDX_W-1:0]        from_q;
  logic [IDX_W-1:0]        to_q;
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic                    rd_vld_q;

  // Result registers
  logic             res_vld_q;
  logic             res_mark_q;
  logic             res_last_q;
  logic             res_rej_q;
  logic [IDX_W-1:0] res_vtx_q;

  // Memory ports
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [IDX_W-1:0]        adj_raddr;
  logic                    adj_re;
  logic [CNT_W-1:0]        mark_rdata;
  logic [IDX_W-1:0]        stk_rdata;
  logic [IDX_W-1:0]        stk_raddr;

  // Search logic
  logic [MAX_VERTICES-1:0] vmask;
  logic [MAX_VERTICES-1:0] row;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] lowbit;
  logic [IDX_W-1:0]        find_idx;
  logic [CNT_W-1:0]        cnt_inc;
  logic [6:0]              n_cfg;

  // Mask of vertices below the active count
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vmask[i] = (CNT_W'(i) < n_q);
    end
  end

  // Pick the lowest unvisited candidate
  assign row    = (rd_vld_q ? adj_rdata : '0) & vmask;
  assign cand   = cmd_i.sel_root ? (~visited_q & vmask) : (row & ~visited_q);
  assign lowbit = cand & (~cand + MAX_VERTICES'(1));

  always_comb begin
    find_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (lowbit[i]) begin
        find_idx = find_idx | IDX_W'(i);
      end
    end
  end

  assign cnt_inc = cnt_q + CNT_W'(1);

  assign sts_o.found     = |cand;
  assign sts_o.depth_one = (depth_q == CNT_W'(1));
  assign sts_o.out_last  = ((CNT_W'(out_idx_q) + CNT_W'(1)) == n_q);
  assign sts_o.edge_bad  = ({1'b0, from_vertex_i} >= 7'(n_q)) ||
                           ({1'b0, to_vertex_i} >= 7'(n_q));

  // Clamp the vertex count into range
  always_comb begin
    if (cfg_data_i == 7'd0) begin
      n_cfg = 7'd1;
    end else if (cfg_data_i > MaxN) begin
      n_cfg = MaxN;
    end else begin
      n_cfg = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CNT_W'(MAX_VERTICES);
    end else if (cmd_i.cfg_we) begin
      n_q <= CNT_W'(n_cfg);
    end
  end

  // Adjacency row read address
  always_comb begin
    adj_raddr = find_idx;
    if (cmd_i.edge_rd) begin
      adj_raddr = from_vertex_i[IDX_W-1:0];
    end else if (cmd_i.pop_load) begin
      adj_raddr = stk_rdata;
    end
  end

  assign adj_re    = cmd_i.edge_rd | cmd_i.visit | cmd_i.pop_load;
  assign adj_wdata = (rd_vld_q ? adj_rdata : '0) | (MAX_VERTICES'(1) << to_q);
  assign stk_raddr = IDX_W'(depth_q - CNT_W'(2));

  // Row valid bits stand in for the cleared matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (adj_re) begin
        rd_vld_q <= row_vld_q[adj_raddr];
      end
      if (cmd_i.edge_wr) begin
        row_vld_q[from_q] <= 1'b1;
      end
    end
  end

  // Hold the pending edge
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_rd) begin
      from_q <= from_vertex_i[IDX_W-1:0];
      to_q   <= to_vertex_i[IDX_W-1:0];
    end
  end

  // Traversal state: visit, push, pop, output index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      cnt_q     <= '0;
      depth_q   <= '0;
      out_idx_q <= '0;
    end else begin
      if (cmd_i.run_init) begin
        visited_q <= '0;
        cnt_q     <= '0;
        depth_q   <= '0;
        out_idx_q <= '0;
      end else begin
        if (cmd_i.visit) begin
          visited_q[find_idx] <= 1'b1;
          cnt_q               <= cnt_inc;
          depth_q             <= depth_q + CNT_W'(1);
        end else if (cmd_i.pop) begin
          depth_q <= depth_q - CNT_W'(1);
        end
        if (cmd_i.out_step) begin
          out_idx_q <= out_idx_q + IDX_W'(1);
        end
      end
    end
  end

  // Result register: strobe for one cycle per request outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.edge_rej | cmd_i.edge_wr | cmd_i.out_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_rej | cmd_i.edge_wr) begin
      res_mark_q <= 1'b0;
      res_last_q <= 1'b0;
      res_rej_q  <= cmd_i.edge_rej;
      res_vtx_q  <= '0;
    end else if (cmd_i.out_step) begin
      res_mark_q <= 1'b1;
      res_last_q <= sts_o.out_last;
      res_rej_q  <= 1'b0;
      res_vtx_q  <= out_idx_q;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign vertex_index_o  = 6'(res_vtx_q);
  assign mark_value_o    = res_mark_q ? 7'(mark_rdata) : 7'd0;
  assign last_item_o     = res_last_q;
  assign edge_rejected_o = res_rej_q;

  dvom_ram #(
    .WIDTH(MAX_VERTICES),
    .DEPTH(MAX_VERTICES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.edge_wr),
    .waddr_i(from_q),
    .wdata_i(adj_wdata),
    .re_i   (adj_re),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  dvom_ram #(
    .WIDTH(CNT_W),
    .DEPTH(MAX_VERTICES)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.visit),
    .waddr_i(find_idx),
    .wdata_i(cnt_inc),
    .re_i   (cmd_i.out_step),
    .raddr_i(out_idx_q),
    .rdata_o(mark_rdata)
  );

  dvom_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_VERTICES)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.visit),
    .waddr_i(depth_q[IDX_W-1:0]),
    .wdata_i(find_idx),
    .re_i   (cmd_i.pop),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= n_q) else $error("stack depth exceeds vertex count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.visit |-> (cnt_q < n_q)) else $error("visit counter exceeds vertex count");

  a_visit_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.visit |-> !visited_q[find_idx]) else $error("vertex visited twice");

  a_mark_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_mark_q) |-> (mark_rdata != '0))
    else $error("reported vertex was never numbered");
`endif

endmodule
